// ===== design/ssdt_pkg.sv =====
`default_nettype none

package ssdt_pkg;

  // Stream bus widths
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // Socket configuration registers
  localparam int SOCK_REGS = 4;
  localparam int SOCK_W    = 19;
  localparam int CFG_IDX_W = 2;

  typedef logic [SOCK_W-1:0] sock_reg_t;

  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_CONNECT = 2'd1,
    OP_ACCEPT  = 2'd2,
    OP_CLOSE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEW  = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  // One stream table entry as kept in memory; the live flag is held in flops.
  typedef struct packed {
    logic [1:0]  owner;
    logic [31:0] ip;
    logic [15:0] port;
    logic        accepted;
    logic        udp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    opcode_e     opcode;
    logic [1:0]  socket_index;
    logic [2:0]  stream_index;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic        is_udp;
  } req_t;

  function automatic logic sock_used(input sock_reg_t r);
    return r[0];
  endfunction

  function automatic logic sock_listen(input sock_reg_t r);
    return r[1];
  endfunction

  function automatic logic sock_udp(input sock_reg_t r);
    return r[2];
  endfunction

  function automatic logic [15:0] sock_port(input sock_reg_t r);
    return r[18:3];
  endfunction

endpackage

`default_nettype wire

// ===== design/socket_stream_demux_table.sv =====
`default_nettype none

// Connection lookup table for up to STREAM_COUNT streams owned by up to
// SOCKET_COUNT configured sockets. Each request on the slave stream is one
// of: incoming packet (match a live stream by protocol, remote IP and port,
// else open a pending stream on the first listening socket whose protocol
// and local port fit), connect (open an accepted stream for a non-listening
// socket), accept (mark the first pending stream of a listening socket) or
// close (free a stream). Every request returns exactly one result: status
// 0 matched/done, 1 new stream, 2 failed (stream id and mode then read 0).
// Stream entries sit in a single-port-read synchronous RAM; live and
// written flags are flops cleared by reset, so no clearing pass is needed.
// Packet, connect and accept scan the whole table, reading one table entry
// per cycle through the RAM read port; close reads only its own entry. A
// finished result sits in the output register while the next request is
// already being scanned. The user must write socket registers through cfg_*
// only while no request is in flight; the block does not enforce it.

module socket_stream_demux_table #(
  parameter int STREAM_COUNT = 8,
  parameter int SOCKET_COUNT = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ssdt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ssdt_pkg::SOCK_W-1:0]        cfg_wdata_i,
  // request stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [1:0] socket_index, [4:2] stream_index, [36:5] remote_ip,
  // [52:37] remote_port, [68:53] local_port, [71:69] zero
  input  wire logic [ssdt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] opcode, [2] is_udp
  input  wire logic [ssdt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [2:0] stream_id, [3] stream_udp, [7:4] zero
  output logic      [ssdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic      [ssdt_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  import ssdt_pkg::*;

  localparam int IdxW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
  localparam int CntW = $clog2(STREAM_COUNT + 1);
  localparam int ExtW = (IdxW > 3) ? IdxW : 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_PUSH
  } state_e;

  state_e state_q;

  // socket registers
  sock_reg_t sock_q [SOCK_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SOCK_REGS; i++) begin
        sock_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      sock_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // latched request
  req_t req_q;
  req_t req_in;

  always_comb begin
    req_in.opcode       = opcode_e'(s_axis_tuser[1:0]);
    req_in.is_udp       = s_axis_tuser[2];
    req_in.socket_index = s_axis_tdata[1:0];
    req_in.stream_index = s_axis_tdata[4:2];
    req_in.remote_ip    = s_axis_tdata[36:5];
    req_in.remote_port  = s_axis_tdata[52:37];
    req_in.local_port   = s_axis_tdata[68:53];
  end

  // stream table flags
  logic [STREAM_COUNT-1:0] live_q;
  logic [STREAM_COUNT-1:0] wr_q;   // entry written at least once since reset

  // scan state
  logic [CntW-1:0] cnt_q;
  logic            rvld_q;
  logic [IdxW-1:0] ridx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t          hit_ent_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;

  // result
  status_e         res_status_q;
  logic [IdxW-1:0] res_idx_q;
  logic            res_udp_q;

  logic            out_valid_q;
  status_e         out_status_q;
  logic [2:0]      out_id_q;
  logic            out_udp_q;

  // RAM
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IdxW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ram_ent;

  assign ram_ent = entry_t'(ram_rdata);

  // request decode
  logic            si_ok;
  logic            sk_ok;
  logic [ExtW-1:0] si_ext;
  logic [IdxW-1:0] si_idx;
  sock_reg_t       sk_reg;

  assign si_ok  = 32'(req_q.stream_index) < STREAM_COUNT;
  assign sk_ok  = 32'(req_q.socket_index) < SOCKET_COUNT;
  assign si_ext = ExtW'(req_q.stream_index);
  assign si_idx = si_ext[IdxW-1:0];
  assign sk_reg = sock_q[req_q.socket_index];

  // scan read issue
  logic scan_re;
  assign scan_re   = (state_q == S_SCAN) && (cnt_q < CntW'(STREAM_COUNT));
  assign ram_re    = scan_re || ((state_q == S_READ) && si_ok);
  assign ram_raddr = (state_q == S_READ) ? si_idx : cnt_q[IdxW-1:0];

  // candidate check on the entry that came back this cycle
  logic live_r;
  logic cand;

  always_comb begin
    live_r = live_q[ridx_q];
    case (req_q.opcode)
      OP_PACKET: cand = live_r && (sock_udp(sock_q[ram_ent.owner]) == req_q.is_udp) &&
                        (ram_ent.port == req_q.remote_port) &&
                        (ram_ent.ip == req_q.remote_ip);
      OP_ACCEPT: cand = live_r && !ram_ent.accepted &&
                        (ram_ent.owner == req_q.socket_index);
      default:   cand = 1'b0;
    endcase
  end

  // first listening socket for the packet's protocol and destination port
  logic       lsn_found;
  logic [1:0] lsn_idx;
  logic       lsn_udp;

  always_comb begin
    lsn_found = 1'b0;
    lsn_idx   = '0;
    lsn_udp   = 1'b0;
    for (int i = 0; i < SOCKET_COUNT; i++) begin
      if (!lsn_found && sock_used(sock_q[i]) && sock_listen(sock_q[i]) &&
          (sock_udp(sock_q[i]) == req_q.is_udp) &&
          (sock_port(sock_q[i]) == req_q.local_port)) begin
        lsn_found = 1'b1;
        lsn_idx   = 2'(i);
        lsn_udp   = sock_udp(sock_q[i]);
      end
    end
  end

  // decision after the scan
  logic            dec_we;
  logic [IdxW-1:0] dec_waddr;
  entry_t          dec_wdata;
  logic            dec_close;
  status_e         dec_status;
  logic [IdxW-1:0] dec_idx;
  logic            dec_udp;

  always_comb begin
    dec_we     = 1'b0;
    dec_waddr  = free_idx_q;
    dec_wdata  = '0;
    dec_close  = 1'b0;
    dec_status = ST_FAIL;
    dec_idx    = '0;
    dec_udp    = 1'b0;
    unique case (req_q.opcode)
      OP_PACKET: begin
        if (hit_q) begin
          dec_status = ST_OK;
          dec_idx    = hit_idx_q;
          dec_udp    = hit_ent_q.udp;
        end else if (lsn_found && free_q) begin
          dec_we             = 1'b1;
          dec_wdata.owner    = lsn_idx;
          dec_wdata.ip       = req_q.remote_ip;
          dec_wdata.port     = req_q.remote_port;
          dec_wdata.accepted = 1'b0;
          dec_wdata.udp      = lsn_udp;
          dec_status         = ST_NEW;
          dec_idx            = free_idx_q;
          dec_udp            = lsn_udp;
        end
      end
      OP_CONNECT: begin
        if (sk_ok && sock_used(sk_reg) && !sock_listen(sk_reg) && free_q) begin
          dec_we             = 1'b1;
          dec_wdata.owner    = req_q.socket_index;
          dec_wdata.ip       = req_q.remote_ip;
          dec_wdata.port     = req_q.remote_port;
          dec_wdata.accepted = 1'b1;
          dec_wdata.udp      = sock_udp(sk_reg);
          dec_status         = ST_NEW;
          dec_idx            = free_idx_q;
          dec_udp            = sock_udp(sk_reg);
        end
      end
      OP_ACCEPT: begin
        if (sk_ok && sock_used(sk_reg) && sock_listen(sk_reg) && hit_q) begin
          dec_we             = 1'b1;
          dec_waddr          = hit_idx_q;
          dec_wdata          = hit_ent_q;
          dec_wdata.accepted = 1'b1;
          dec_status         = ST_OK;
          dec_idx            = hit_idx_q;
          dec_udp            = hit_ent_q.udp;
        end
      end
      OP_CLOSE: begin
        if (si_ok) begin
          dec_close  = 1'b1;
          dec_status = ST_OK;
          dec_idx    = si_idx;
          // never-written entry reads as the reset value
          dec_udp    = ram_ent.udp && wr_q[si_idx];
        end
      end
    endcase
  end

  assign ram_we    = (state_q == S_DECIDE) && dec_we;
  assign ram_waddr = dec_waddr;
  assign ram_wdata = ENTRY_W'(dec_wdata);

  ssdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STREAM_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic            push_fire;
  logic [ExtW-1:0] res_id_ext;

  assign push_fire  = (state_q == S_PUSH) && (!out_valid_q || m_axis_tready);
  assign res_id_ext = ExtW'(res_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      rvld_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvld_q <= scan_re;
      ridx_q <= cnt_q[IdxW-1:0];

      if (push_fire) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_id_q     <= res_id_ext[2:0];
        out_udp_q    <= res_udp_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q  <= req_in;
            cnt_q  <= '0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            state_q <= (req_in.opcode == OP_CLOSE) ? S_READ : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_re) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rvld_q) begin
            if (!hit_q && cand) begin
              hit_q     <= 1'b1;
              hit_idx_q <= ridx_q;
              hit_ent_q <= ram_ent;
            end
            if (!free_q && !live_r) begin
              free_q     <= 1'b1;
              free_idx_q <= ridx_q;
            end
          end
          // last entry is checked in the cycle the count reaches the end
          if (cnt_q == CntW'(STREAM_COUNT)) begin
            state_q <= S_DECIDE;
          end
        end
        S_READ: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (dec_we) begin
            live_q[dec_waddr] <= 1'b1;
            wr_q[dec_waddr]   <= 1'b1;
          end
          if (dec_close) begin
            live_q[si_idx] <= 1'b0;
          end
          res_status_q <= dec_status;
          res_idx_q    <= dec_idx;
          res_udp_q    <= dec_udp;
          state_q      <= S_PUSH;
        end
        S_PUSH: begin
          if (push_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {4'b0000, out_udp_q, out_id_q};

  // an entry written by the decision is live and readable afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (live_q[$past(ram_waddr)] && wr_q[$past(ram_waddr)]))
    else $error("allocated stream not marked live");

  // a failed request carries zero id and mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FAIL)) |-> (m_axis_tdata[3:0] == 4'b0000))
    else $error("failed result with nonzero stream fields");

  // scan counter stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STREAM_COUNT))
    else $error("scan counter past table end");

  // table is never written while a scan read is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write overlaps table read");

endmodule

`default_nettype wire

// ===== design/ssdt_ram.sv =====
`default_nettype none

module ssdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/socket_stream_demux_table_tb.sv =====
`default_nettype none

// Self-checking bench for the stream demux table. A driver feeds requests
// from a queue at the falling edge, a monitor at the rising edge runs every
// accepted request through a local copy of the table and checks each
// result against the oldest predicted one. Socket registers are rewritten
// between phases, only while the block is idle.
module socket_stream_demux_table_tb;
  import ssdt_pkg::*;

  localparam int NSTREAMS = 8;
  localparam int NSOCKETS = 4;

  typedef struct {
    status_e    status;
    logic [2:0] id;
    logic       udp;
  } lookup_result_t;

  typedef struct {
    logic [1:0]  owner;
    logic [31:0] ip;
    logic [15:0] port;
    logic        acc;
    logic        live;
    logic        udp;
  } stream_slot_t;

  // DUT inputs, known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [SOCK_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tready = 1'b0;

  // DUT outputs
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // Predicted table state and socket registers
  stream_slot_t   streams [NSTREAMS];
  sock_reg_t      sock_cfg [NSOCKETS];

  // Socket values written in the current phase; steers random ports
  sock_reg_t      phase_cfg [NSOCKETS];

  req_t           request_queue [$];
  lookup_result_t pending_results [$];
  req_t           cur_req;
  logic           req_fire = 1'b0;

  int             send_idle = 12;
  int             recv_idle = 66;
  int             err_count = 0;

  socket_stream_demux_table #(
    .STREAM_COUNT(NSTREAMS),
    .SOCKET_COUNT(NSOCKETS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic int first_free_slot();
    for (int i = 0; i < NSTREAMS; i++)
      if (!streams[i].live) return i;
    return -1;
  endfunction

  // Applies one request to the local table and returns the result the
  // block must produce for it.
  function automatic lookup_result_t apply_request(input req_t r);
    lookup_result_t res;
    int             hit;
    int             fr;
    status_e        st;
    logic           done;
    sock_reg_t      sr;
    hit  = -1;
    st   = ST_FAIL;
    done = 1'b0;
    case (r.opcode)
      OP_PACKET: begin
        // live match uses the owner's protocol bit even if the owner is gone
        for (int i = 0; i < NSTREAMS; i++)
          if (hit < 0 && streams[i].live &&
              sock_cfg[streams[i].owner][2] == r.is_udp &&
              streams[i].port == r.remote_port && streams[i].ip == r.remote_ip) begin
            hit = i;
            st  = ST_OK;
          end
        // only the first fitting listener is tried, full table drops
        if (hit < 0)
          for (int s = 0; s < NSOCKETS; s++) begin
            sr = sock_cfg[s];
            if (!done && sr[0] && sr[1] && sr[2] == r.is_udp &&
                sr[18:3] == r.local_port) begin
              done = 1'b1;
              fr = first_free_slot();
              if (fr >= 0) begin
                streams[fr] = '{owner: 2'(s), ip: r.remote_ip, port: r.remote_port,
                                acc: 1'b0, live: 1'b1, udp: sr[2]};
                hit = fr;
                st  = ST_NEW;
              end
            end
          end
      end
      OP_CONNECT: begin
        sr = sock_cfg[r.socket_index];
        if (sr[0] && !sr[1]) begin
          fr = first_free_slot();
          if (fr >= 0) begin
            streams[fr] = '{owner: r.socket_index, ip: r.remote_ip,
                            port: r.remote_port, acc: 1'b1, live: 1'b1, udp: sr[2]};
            hit = fr;
            st  = ST_NEW;
          end
        end
      end
      OP_ACCEPT: begin
        sr = sock_cfg[r.socket_index];
        if (sr[0] && sr[1])
          for (int i = 0; i < NSTREAMS; i++)
            if (!done && streams[i].live && !streams[i].acc &&
                streams[i].owner == r.socket_index) begin
              done = 1'b1;
              streams[i].acc = 1'b1;
              hit = i;
              st  = ST_OK;
            end
      end
      default: begin
        // close: a free stream still reports its stored mode
        streams[r.stream_index].live = 1'b0;
        hit = int'(r.stream_index);
        st  = ST_OK;
      end
    endcase
    if (hit < 0) begin
      res = '{status: ST_FAIL, id: 3'd0, udp: 1'b0};
    end else begin
      res = '{status: st, id: 3'(hit), udp: streams[hit].udp};
    end
    return res;
  endfunction

  // Driver: requests and receiver stalls change at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
      if (!s_axis_tvalid || req_fire) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_req.local_port, cur_req.remote_port,
                            cur_req.remote_ip, cur_req.stream_index,
                            cur_req.socket_index};
          s_axis_tuser  <= {cur_req.is_udp, cur_req.opcode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted result.
  always @(posedge clk_i) begin
    lookup_result_t want;
    req_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) sock_cfg[cfg_idx_i] = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(apply_request(cur_req));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
          if (m_axis_tdata[2:0] != want.id)
            report_mismatch($sformatf("stream_id %0d, want %0d",
                                      m_axis_tdata[2:0], want.id));
          if (m_axis_tdata[3] != want.udp)
            report_mismatch($sformatf("stream_udp %0b, want %0b",
                                      m_axis_tdata[3], want.udp));
        end
      end
    end
  end

  task automatic add_req(input opcode_e op, input logic [1:0] sk, input logic [2:0] si,
                         input logic [31:0] ip, input logic [15:0] rp,
                         input logic [15:0] lp, input logic udp);
    req_t r;
    r.opcode       = op;
    r.socket_index = sk;
    r.stream_index = si;
    r.remote_ip    = ip;
    r.remote_port  = rp;
    r.local_port   = lp;
    r.is_udp       = udp;
    request_queue.push_back(r);
  endtask

  // Small address pools so that flows repeat and hit live streams.
  function automatic logic [31:0] pick_ip();
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0A00_0001;
      3: return 32'hC0A8_0101;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd80;
      3: return 16'd443;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sock_reg_t rand_socket();
    sock_reg_t v;
    v[0]    = ($urandom_range(9) < 8);
    v[1]    = 1'($urandom_range(1));
    v[2]    = 1'($urandom_range(1));
    v[18:3] = pick_port();
    return v;
  endfunction

  function automatic req_t make_request();
    req_t r;
    int   pick;
    // junk in unused fields keeps every bit moving
    r.socket_index = 2'($urandom);
    r.stream_index = 3'($urandom);
    r.remote_ip    = $urandom;
    r.remote_port  = 16'($urandom);
    r.local_port   = 16'($urandom);
    r.is_udp       = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.opcode = OP_PACKET;
      if ($urandom_range(3) != 0) r.remote_ip = pick_ip();
      if ($urandom_range(3) != 0) r.remote_port = pick_port();
      if ($urandom_range(4) != 0) r.local_port = phase_cfg[$urandom_range(3)][18:3];
    end else if (pick < 65) begin
      r.opcode = OP_CONNECT;
      r.remote_ip   = pick_ip();
      r.remote_port = pick_port();
    end else if (pick < 80) begin
      r.opcode = OP_ACCEPT;
    end else begin
      r.opcode = OP_CLOSE;
    end
    return r;
  endfunction

  task automatic write_sockets();
    for (int i = 0; i < NSOCKETS; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= phase_cfg[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block is idle once every request went in and every result came out.
  task automatic wait_drained();
    wait (request_queue.size() == 0 && !s_axis_tvalid && pending_results.size() == 0);
    repeat (NSTREAMS + 8) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NSTREAMS; i++) streams[i] = '{default: '0};
    for (int i = 0; i < NSOCKETS; i++) sock_cfg[i] = '0;
    for (int i = 0; i < NSOCKETS; i++) phase_cfg[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: nothing listens, closing a free stream still works
    add_req(OP_PACKET, 2'd0, 3'd0, 32'h1, 16'h1, 16'h0, 1'b0);
    add_req(OP_CLOSE,  2'd0, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    wait_drained();

    // tcp listener on 80, udp listener on ffff, udp client, unused socket
    phase_cfg[0] = {16'd80, 3'b011};
    phase_cfg[1] = {16'hFFFF, 3'b111};
    phase_cfg[2] = {16'd0, 3'b101};
    phase_cfg[3] = '0;
    write_sockets();
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h0A00_0001, 16'd1234, 16'd80, 1'b0);
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h0A00_0001, 16'd1234, 16'd80, 1'b0);
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h0A00_0001, 16'd1234, 16'd80, 1'b1);
    add_req(OP_PACKET,  2'd0, 3'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    add_req(OP_ACCEPT,  2'd0, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    add_req(OP_ACCEPT,  2'd0, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0); // nothing pending
    add_req(OP_ACCEPT,  2'd1, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    add_req(OP_ACCEPT,  2'd2, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0); // not listening
    add_req(OP_ACCEPT,  2'd3, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0); // not in use
    add_req(OP_CONNECT, 2'd2, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    add_req(OP_CONNECT, 2'd0, 3'd0, 32'h1, 16'h1, 16'h0, 1'b0); // listener
    add_req(OP_CONNECT, 2'd3, 3'd0, 32'h1, 16'h1, 16'h0, 1'b0); // not in use
    add_req(OP_CLOSE,   2'd0, 3'd7, 32'h0, 16'h0, 16'h0, 1'b0); // free entry
    add_req(OP_CLOSE,   2'd0, 3'd0, 32'h0, 16'h0, 16'h0, 1'b0);
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h0A00_0001, 16'd1234, 16'd80, 1'b0);
    for (int i = 0; i < 5; i++)
      add_req(OP_CONNECT, 2'd2, 3'd0, 32'hC0A8_0100 + i, 16'(i), 16'h0, 1'b0);
    add_req(OP_CONNECT, 2'd2, 3'd0, 32'h5, 16'h5, 16'h0, 1'b0);    // table full
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h7, 16'h7, 16'd80, 1'b0);   // dropped, full
    add_req(OP_PACKET,  2'd0, 3'd0, 32'h0, 16'h0, 16'h0, 1'b1);    // hits connected
    add_req(OP_CLOSE,   2'd0, 3'd3, 32'h0, 16'h0, 16'h0, 1'b0);
    add_req(OP_CLOSE,   2'd0, 3'd2, 32'h0, 16'h0, 16'h0, 1'b0);
    wait_drained();

    // random phases; table contents carry over across reconfiguration
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 66;
        recv_idle = 12;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < NSOCKETS; i++) begin
        if (p == 1) phase_cfg[i] = '1;
        else if (p == 3) phase_cfg[i] = '0;
        else phase_cfg[i] = rand_socket();
      end
      write_sockets();
      for (int n = 0; n < 340; n++) request_queue.push_back(make_request());
      wait_drained();
    end

    if (err_count == 0) begin
      $display("socket_stream_demux_table_tb: done, clean");
    end else begin
      $display("socket_stream_demux_table_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1_600_000;
    $display("socket_stream_demux_table_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/ssdt_pkg.sv
design/ssdt_ram.sv
design/socket_stream_demux_table.sv
sim/socket_stream_demux_table_tb.sv
